// ===== sv/sub_pkg.sv =====
// ----------------------------------------------------------------------------
// sub_pkg: shared constants and types for the spherical unit basis block
// Widths of the squaring, division and square-root pipelines, lane codes
// and the sideband record that travels beside the lanes.
// ----------------------------------------------------------------------------
package sub_pkg;

    // input component width and output fraction bits
    localparam int IN_W    = 24;
    localparam int OUT_F   = 15;
    localparam int OUT_W   = OUT_F + 1;

    // magnitude, square and product widths
    localparam int SQ_W    = 2 * IN_W;
    localparam int PROD_W  = 4 * IN_W;

    // quotient of num * 2^(2F+2) / den, root and root remainder widths
    localparam int QUO_W   = 2 * OUT_F + 3;
    localparam int ROOT_W  = OUT_F + 2;
    localparam int REM_W   = QUO_W + 1;

    // pipeline depths
    localparam int LANE_ST = QUO_W + ROOT_W;
    localparam int PRE_ST  = 5;
    localparam int N_ST    = PRE_ST + LANE_ST + 1;

    // lane codes
    localparam int N_LANE  = 8;
    localparam int LN_RX   = 0;
    localparam int LN_RY   = 1;
    localparam int LN_RZ   = 2;
    localparam int LN_AX   = 3;
    localparam int LN_AY   = 4;
    localparam int LN_EX   = 5;
    localparam int LN_EY   = 6;
    localparam int LN_EZ   = 7;

    // sign and special-case flags of one vector
    typedef struct packed {
        logic x_neg;
        logic x_pos;
        logic y_neg;
        logic y_pos;
        logic z_neg;
        logic z_zero;
        logic axis;
        logic zero;
    } t_side;

endpackage

// ===== sv/sub_in_if.sv =====
// ----------------------------------------------------------------------------
// sub_in_if: input channel
// One signed offset vector per transfer.
// ----------------------------------------------------------------------------
interface sub_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [sub_pkg::IN_W-1:0] vec_x;
    logic signed [sub_pkg::IN_W-1:0] vec_y;
    logic signed [sub_pkg::IN_W-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// ===== sv/sub_out_if.sv =====
// ----------------------------------------------------------------------------
// sub_out_if: output channel
// Three unit vectors in signed fixed point and two flags per transfer.
// ----------------------------------------------------------------------------
interface sub_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [sub_pkg::OUT_W-1:0] radial_x;
    logic signed [sub_pkg::OUT_W-1:0] radial_y;
    logic signed [sub_pkg::OUT_W-1:0] radial_z;
    logic signed [sub_pkg::OUT_W-1:0] azim_x;
    logic signed [sub_pkg::OUT_W-1:0] azim_y;
    logic signed [sub_pkg::OUT_W-1:0] azim_z;
    logic signed [sub_pkg::OUT_W-1:0] elev_x;
    logic signed [sub_pkg::OUT_W-1:0] elev_y;
    logic signed [sub_pkg::OUT_W-1:0] elev_z;
    logic                             on_axis;
    logic                             zero_vector;

    modport source (output valid, output radial_x, output radial_y, output radial_z,
                    output azim_x, output azim_y, output azim_z,
                    output elev_x, output elev_y, output elev_z,
                    output on_axis, output zero_vector, input ready);
    modport sink   (input valid, input radial_x, input radial_y, input radial_z,
                    input azim_x, input azim_y, input azim_z,
                    input elev_x, input elev_y, input elev_z,
                    input on_axis, input zero_vector, output ready);
endinterface

// ===== sv/sub_lane.sv =====
// ----------------------------------------------------------------------------
// sub_lane: one ratio lane
// Restoring divider giving floor(num * 2^(2F+2) / den), one quotient bit per
// stage, followed by a restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module sub_lane (
    input  logic                         i_clk,
    input  logic [sub_pkg::LANE_ST-1:0]  i_en,
    input  logic [sub_pkg::PROD_W-1:0]   i_num,
    input  logic [sub_pkg::PROD_W-1:0]   i_den,
    output logic [sub_pkg::ROOT_W-1:0]   o_root
);

    localparam int PW = sub_pkg::PROD_W;
    localparam int QW = sub_pkg::QUO_W;
    localparam int RW = sub_pkg::ROOT_W;
    localparam int MW = sub_pkg::REM_W;

    logic [PW-1:0] r_rem  [0:QW-2];
    logic [PW-1:0] r_den  [0:QW-2];
    logic [QW-1:0] r_quo  [0:QW-1];
    logic [MW-1:0] r_srem [0:RW-2];
    logic [RW-1:0] r_root [0:RW-1];

    // divider stages, most significant quotient bit first
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [PW:0]   w_trial;
        logic [PW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_trial = {1'b0, i_num};
            assign w_den   = i_den;
            assign w_quo   = '0;
        end else begin : g_next
            assign w_trial = {r_rem[k-1], 1'b0};
            assign w_den   = r_den[k-1];
            assign w_quo   = r_quo[k-1];
        end

        assign w_ge = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_quo[k] <= {w_quo[QW-2:0], w_ge};
            end
        end

        if (k < QW - 1) begin : g_rem
            logic [PW:0] w_diff;
            assign w_diff = w_trial - {1'b0, w_den};
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k] <= w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
                    r_den[k] <= w_den;
                end
            end
        end
    end

    // square-root stages, most significant root bit first
    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int K = RW - 1 - j;
        logic [MW-1:0] w_rem;
        logic [RW-1:0] w_root;
        logic [MW-1:0] w_trial;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_rem  = {1'b0, r_quo[QW-1]};
            assign w_root = '0;
        end else begin : g_next
            assign w_rem  = r_srem[j-1];
            assign w_root = r_root[j-1];
        end

        assign w_trial = (MW'(w_root) << (K + 1)) + (MW'(1) << (2 * K));
        assign w_ge    = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en[QW+j]) begin
                r_root[j] <= w_ge ? (w_root | (RW'(1) << K)) : w_root;
            end
        end

        if (j < RW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en[QW+j]) begin
                    r_srem[j] <= w_ge ? (w_rem - w_trial) : w_rem;
                end
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== sv/spherical_unit_basis.sv =====
// ----------------------------------------------------------------------------
// spherical_unit_basis: local spherical unit vectors of an offset vector
// Throughput: one vector per cycle while the output is not stalled; each of
//   the eight ratio lanes is a 33-stage divider followed by a 17-stage
//   square root, fully pipelined.
// Reset: synchronous, active low; clears the stage valid bits only.
// Stalls close up empty stages, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module spherical_unit_basis (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sub_in_if.sink     i_in,
    sub_out_if.source  o_out
);

    localparam int W   = sub_pkg::IN_W;
    localparam int SW  = sub_pkg::SQ_W;
    localparam int PW  = sub_pkg::PROD_W;
    localparam int OW  = sub_pkg::OUT_W;
    localparam int RW  = sub_pkg::ROOT_W;
    localparam int NS  = sub_pkg::N_ST;
    localparam int LS  = sub_pkg::LANE_ST;
    localparam int PS  = sub_pkg::PRE_ST;
    localparam int NL  = sub_pkg::N_LANE;
    localparam logic [OW-1:0] Q_MAX = {1'b0, {sub_pkg::OUT_F{1'b1}}};

    // sign and saturate one rounded magnitude
    function automatic logic [OW-1:0] to_out(input logic neg, input logic [OW-1:0] q);
        logic [OW-1:0] res;
        if (neg) begin
            res = ~q + OW'(1);
        end else begin
            res = (q > Q_MAX) ? Q_MAX : q;
        end
        return res;
    endfunction

    logic [NS-1:0]          r_v;
    logic [NS-1:0]          w_en;
    sub_pkg::t_side         r_side [1:NS-2];
    sub_pkg::t_side         w_side;

    logic signed [W-1:0]    r_x0, r_y0, r_z0;
    logic [W-1:0]           w_ax, w_ay, w_az;
    logic [SW-1:0]          r_x2_1, r_y2_1, r_z2_1;
    logic [SW-1:0]          r_x2_2, r_y2_2, r_z2_2, r_rho2_2, r_r2_2;
    logic [SW-1:0]          r_x2_3, r_y2_3, r_z2_3, r_rho2_3, r_r2_3;
    logic [SW-1:0]          r_xz_pp [0:3];
    logic [SW-1:0]          r_yz_pp [0:3];
    logic [SW-1:0]          r_rr_pp [0:3];
    logic [PW-1:0]          r_num [0:NL-1];
    logic [PW-1:0]          r_den [0:NL-1];
    logic [RW-1:0]          w_root [0:NL-1];
    logic [OW-1:0]          w_q [0:NL-1];

    logic [OW-1:0]          r_rad_x, r_rad_y, r_rad_z;
    logic [OW-1:0]          r_az_x, r_az_y;
    logic [OW-1:0]          r_el_x, r_el_y, r_el_z;
    logic                   r_on_axis, r_zero;

    // advance a stage when it is empty or the next one advances
    for (genvar i = 0; i < NS - 1; i++) begin : g_en
        assign w_en[i] = !r_v[i] || w_en[i+1];
    end
    assign w_en[NS-1] = !r_v[NS-1] || o_out.ready;
    assign i_in.ready = w_en[0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // capture input vector
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x0 <= i_in.vec_x;
            r_y0 <= i_in.vec_y;
            r_z0 <= i_in.vec_z;
        end
    end

    // magnitudes and flags
    always_comb begin
        w_ax          = r_x0[W-1] ? W'(-r_x0) : W'(r_x0);
        w_ay          = r_y0[W-1] ? W'(-r_y0) : W'(r_y0);
        w_az          = r_z0[W-1] ? W'(-r_z0) : W'(r_z0);
        w_side.x_neg  = r_x0[W-1];
        w_side.x_pos  = !r_x0[W-1] && (r_x0 != '0);
        w_side.y_neg  = r_y0[W-1];
        w_side.y_pos  = !r_y0[W-1] && (r_y0 != '0);
        w_side.z_neg  = r_z0[W-1];
        w_side.z_zero = (r_z0 == '0);
        w_side.axis   = (r_x0 == '0) && (r_y0 == '0);
        w_side.zero   = w_side.axis && w_side.z_zero;
    end

    // square the components
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_x2_1    <= SW'(w_ax) * SW'(w_ax);
            r_y2_1    <= SW'(w_ay) * SW'(w_ay);
            r_z2_1    <= SW'(w_az) * SW'(w_az);
        end
    end

    // sideband shift line
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_side[1] <= w_side;
        end
        for (int i = 2; i < NS - 1; i++) begin
            if (w_en[i]) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // form rho^2 and r^2
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_x2_2   <= r_x2_1;
            r_y2_2   <= r_y2_1;
            r_z2_2   <= r_z2_1;
            r_rho2_2 <= r_x2_1 + r_y2_1;
            r_r2_2   <= r_x2_1 + r_y2_1 + r_z2_1;
        end
    end

    // partial products of the wide elevation terms
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_x2_3     <= r_x2_2;
            r_y2_3     <= r_y2_2;
            r_z2_3     <= r_z2_2;
            r_rho2_3   <= r_rho2_2;
            r_r2_3     <= r_r2_2;
            r_xz_pp[0] <= SW'(r_x2_2[W-1:0])  * SW'(r_z2_2[W-1:0]);
            r_xz_pp[1] <= SW'(r_x2_2[W-1:0])  * SW'(r_z2_2[SW-1:W]);
            r_xz_pp[2] <= SW'(r_x2_2[SW-1:W]) * SW'(r_z2_2[W-1:0]);
            r_xz_pp[3] <= SW'(r_x2_2[SW-1:W]) * SW'(r_z2_2[SW-1:W]);
            r_yz_pp[0] <= SW'(r_y2_2[W-1:0])  * SW'(r_z2_2[W-1:0]);
            r_yz_pp[1] <= SW'(r_y2_2[W-1:0])  * SW'(r_z2_2[SW-1:W]);
            r_yz_pp[2] <= SW'(r_y2_2[SW-1:W]) * SW'(r_z2_2[W-1:0]);
            r_yz_pp[3] <= SW'(r_y2_2[SW-1:W]) * SW'(r_z2_2[SW-1:W]);
            r_rr_pp[0] <= SW'(r_rho2_2[W-1:0])  * SW'(r_r2_2[W-1:0]);
            r_rr_pp[1] <= SW'(r_rho2_2[W-1:0])  * SW'(r_r2_2[SW-1:W]);
            r_rr_pp[2] <= SW'(r_rho2_2[SW-1:W]) * SW'(r_r2_2[W-1:0]);
            r_rr_pp[3] <= SW'(r_rho2_2[SW-1:W]) * SW'(r_r2_2[SW-1:W]);
        end
    end

    // sum partial products and load the lane operands
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_num[sub_pkg::LN_RX] <= PW'(r_x2_3);
            r_den[sub_pkg::LN_RX] <= PW'(r_r2_3);
            r_num[sub_pkg::LN_RY] <= PW'(r_y2_3);
            r_den[sub_pkg::LN_RY] <= PW'(r_r2_3);
            r_num[sub_pkg::LN_RZ] <= PW'(r_z2_3);
            r_den[sub_pkg::LN_RZ] <= PW'(r_r2_3);
            r_num[sub_pkg::LN_AX] <= PW'(r_y2_3);
            r_den[sub_pkg::LN_AX] <= PW'(r_rho2_3);
            r_num[sub_pkg::LN_AY] <= PW'(r_x2_3);
            r_den[sub_pkg::LN_AY] <= PW'(r_rho2_3);
            r_num[sub_pkg::LN_EX] <= (PW'(r_xz_pp[3]) << SW)
                                   + ((PW'(r_xz_pp[1]) + PW'(r_xz_pp[2])) << W)
                                   + PW'(r_xz_pp[0]);
            r_num[sub_pkg::LN_EY] <= (PW'(r_yz_pp[3]) << SW)
                                   + ((PW'(r_yz_pp[1]) + PW'(r_yz_pp[2])) << W)
                                   + PW'(r_yz_pp[0]);
            r_den[sub_pkg::LN_EX] <= (PW'(r_rr_pp[3]) << SW)
                                   + ((PW'(r_rr_pp[1]) + PW'(r_rr_pp[2])) << W)
                                   + PW'(r_rr_pp[0]);
            r_den[sub_pkg::LN_EY] <= (PW'(r_rr_pp[3]) << SW)
                                   + ((PW'(r_rr_pp[1]) + PW'(r_rr_pp[2])) << W)
                                   + PW'(r_rr_pp[0]);
            r_num[sub_pkg::LN_EZ] <= PW'(r_rho2_3);
            r_den[sub_pkg::LN_EZ] <= PW'(r_r2_3);
        end
    end

    // ratio lanes: divide, take the root, round to nearest
    for (genvar l = 0; l < NL; l++) begin : g_lane
        sub_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en[PS +: LS]),
            .i_num  (r_num[l]),
            .i_den  (r_den[l]),
            .o_root (w_root[l])
        );
        assign w_q[l] = OW'(({1'b0, w_root[l]} + (RW + 1)'(1)) >> 1);
    end

    // apply signs and special cases into the output register
    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            if (r_side[NS-2].zero) begin
                r_rad_x <= '0;
                r_rad_y <= '0;
                r_rad_z <= '0;
            end else begin
                r_rad_x <= to_out(r_side[NS-2].x_neg, w_q[sub_pkg::LN_RX]);
                r_rad_y <= to_out(r_side[NS-2].y_neg, w_q[sub_pkg::LN_RY]);
                r_rad_z <= to_out(r_side[NS-2].z_neg, w_q[sub_pkg::LN_RZ]);
            end
            if (r_side[NS-2].axis) begin
                r_az_x <= Q_MAX;
                r_az_y <= '0;
                r_el_x <= '0;
                r_el_y <= Q_MAX;
                r_el_z <= '0;
            end else begin
                r_az_x <= to_out(r_side[NS-2].y_pos, w_q[sub_pkg::LN_AX]);
                r_az_y <= to_out(r_side[NS-2].x_neg, w_q[sub_pkg::LN_AY]);
                if (r_side[NS-2].z_zero) begin
                    r_el_x <= '0;
                    r_el_y <= '0;
                    r_el_z <= Q_MAX;
                end else begin
                    r_el_x <= to_out(r_side[NS-2].x_pos, w_q[sub_pkg::LN_EX]);
                    r_el_y <= to_out(r_side[NS-2].y_pos, w_q[sub_pkg::LN_EY]);
                    r_el_z <= to_out(r_side[NS-2].z_neg, w_q[sub_pkg::LN_EZ]);
                end
            end
            r_on_axis <= r_side[NS-2].axis;
            r_zero    <= r_side[NS-2].zero;
        end
    end

    // drive the output channel
    assign o_out.valid       = r_v[NS-1];
    assign o_out.radial_x    = r_rad_x;
    assign o_out.radial_y    = r_rad_y;
    assign o_out.radial_z    = r_rad_z;
    assign o_out.azim_x      = r_az_x;
    assign o_out.azim_y      = r_az_y;
    assign o_out.azim_z      = '0;
    assign o_out.elev_x      = r_el_x;
    assign o_out.elev_y      = r_el_y;
    assign o_out.elev_z      = r_el_z;
    assign o_out.on_axis     = r_on_axis;
    assign o_out.zero_vector = r_zero;

`ifndef SYNTHESIS
    // a stalled result stays in the output register
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] && !o_out.ready |=> r_v[NS-1])
        else $error("output result dropped while stalled");

    // an item waiting in the entry stage stays there
    a_entry_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !w_en[0] |=> r_v[0])
        else $error("entry stage lost an item");

    // on the axis the tangent vectors take their fixed values
    a_axis_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.on_axis |-> (r_az_x == Q_MAX) && (r_el_y == Q_MAX))
        else $error("axis frame values wrong");

    // the zero vector is on the axis and has no radial part
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_vector |->
            o_out.on_axis && (r_rad_x == '0) && (r_rad_y == '0) && (r_rad_z == '0))
        else $error("zero vector flags or radial wrong");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for spherical_unit_basis
// Streams signed offset vectors through the block under random idling and a
// long output hold-off, predicts the three unit vectors and both flags with
// exact rounded-ratio arithmetic, and compares every output transfer in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IN_W      = sub_pkg::IN_W;
    localparam int OUT_F     = sub_pkg::OUT_F;
    localparam int OUT_W     = sub_pkg::OUT_W;
    localparam int PROD_W    = sub_pkg::PROD_W;
    localparam int LATENCY   = 56;
    localparam int WATCH_MAX = 4000;
    localparam int N_RANDOM  = 1100;
    localparam logic [OUT_W-1:0] Q_ONE_SAT = OUT_W'((1 << OUT_F) - 1);

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
    } t_offset;

    typedef struct packed {
        logic [OUT_W-1:0] rx, ry, rz, ax, ay, az, ex, ey, ez;
        logic             axis;
        logic             zero;
    } t_basis;

    logic i_clk;
    logic i_rst_n;

    sub_in_if  in_ch ();
    sub_out_if out_ch ();

    spherical_unit_basis dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_offset offset_q[$];
    t_basis  basis_q[$];
    int      n_err;
    int      n_sent;
    int      n_seen;
    int      n_axis;
    int      n_zero;
    int      idle_cycles;
    int      hold_cycles;
    bit      calm;
    bit      stim_done;

    // exact magnitude of sqrt(a1*a2 / (b1*b2)) * 2^F, rounded half away
    function automatic logic [OUT_W:0] ratio_round(
        logic [PROD_W-1:0] a1, logic [PROD_W-1:0] a2,
        logic [PROD_W-1:0] b1, logic [PROD_W-1:0] b2);
        logic [255:0] num;
        logic [255:0] den;
        logic [OUT_W:0] lo;
        logic [OUT_W:0] hi;
        logic [OUT_W:0] mid;
        logic [63:0] k;
        num = (256'(a1) * 256'(a2)) << (2 * OUT_F + 2);
        lo = 0;
        hi = 1 << OUT_F;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            k = 2 * 64'(mid) - 1;
            den = 256'(k * k) * 256'(b1) * 256'(b2);
            if (den <= num) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // apply sign; saturate +1.0
    function automatic logic [OUT_W-1:0] signed_q(bit neg, logic [OUT_W:0] q);
        if (neg) return OUT_W'(-q);
        if (q > Q_ONE_SAT) return Q_ONE_SAT;
        return OUT_W'(q);
    endfunction

    function automatic t_basis spherical_frame(t_offset v);
        t_basis b;
        logic [PROD_W-1:0] x2, y2, z2, rho2, r2;
        longint sx, sy, sz;
        sx = v.x;
        sy = v.y;
        sz = v.z;
        x2 = PROD_W'(sx * sx);
        y2 = PROD_W'(sy * sy);
        z2 = PROD_W'(sz * sz);
        rho2 = x2 + y2;
        r2 = rho2 + z2;
        b = '0;
        b.axis = (rho2 == 0);
        b.zero = b.axis && (z2 == 0);
        if (!b.zero) begin
            b.rx = signed_q(sx < 0, ratio_round(x2, 1, r2, 1));
            b.ry = signed_q(sy < 0, ratio_round(y2, 1, r2, 1));
            b.rz = signed_q(sz < 0, ratio_round(z2, 1, r2, 1));
        end
        if (b.axis) begin
            b.ax = Q_ONE_SAT;
            b.ey = Q_ONE_SAT;
        end else begin
            b.ax = signed_q(sy > 0, ratio_round(y2, 1, rho2, 1));
            b.ay = signed_q(sx < 0, ratio_round(x2, 1, rho2, 1));
            if (sz == 0) begin
                b.ez = Q_ONE_SAT;
            end else begin
                b.ex = signed_q(sx > 0, ratio_round(x2, z2, rho2, r2));
                b.ey = signed_q(sy > 0, ratio_round(y2, z2, rho2, r2));
                b.ez = signed_q(sz < 0, ratio_round(rho2, 1, r2, 1));
            end
        end
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                   logic [OUT_W-1:0] want);
        n_err++;
        $display("mismatch on result %0d: %s got %h want %h", n_seen, what, got, want);
    endtask

    function automatic logic signed [IN_W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 2) == 0 ? '0 : IN_W'($urandom_range(0, 7)) - 3;
            1: return {1'b1, {(IN_W-1){1'b0}}};
            2: return {1'b0, {(IN_W-1){1'b1}}};
            3: return IN_W'($urandom_range(0, 2047)) - 1024;
            default: return IN_W'($urandom);
        endcase
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // directed vectors, then random
    initial begin
        t_offset v;
        logic signed [IN_W-1:0] mx;
        logic signed [IN_W-1:0] mn;
        mx = {1'b0, {(IN_W-1){1'b1}}};
        mn = {1'b1, {(IN_W-1){1'b0}}};
        offset_q.push_back('{0, 0, 0});
        offset_q.push_back('{0, 0, 1});
        offset_q.push_back('{0, 0, -1});
        offset_q.push_back('{0, 0, mx});
        offset_q.push_back('{0, 0, mn});
        offset_q.push_back('{1, 0, 0});
        offset_q.push_back('{-1, 0, 0});
        offset_q.push_back('{0, 1, 0});
        offset_q.push_back('{0, -1, 0});
        offset_q.push_back('{mx, mx, 0});
        offset_q.push_back('{mn, mn, 0});
        offset_q.push_back('{mx, mx, mx});
        offset_q.push_back('{mn, mn, mn});
        offset_q.push_back('{mn, mx, mn});
        offset_q.push_back('{1, 1, 1});
        offset_q.push_back('{-1, -1, -1});
        offset_q.push_back('{3, 4, 0});
        offset_q.push_back('{3, -4, 12});
        offset_q.push_back('{1, 0, mn});
        offset_q.push_back('{mn, 1, 1});
        offset_q.push_back('{-1, -1, 0});
        for (int i = 0; i < N_RANDOM; i++) begin
            v.x = rand_comp();
            v.y = rand_comp();
            v.z = rand_comp();
            offset_q.push_back(v);
        end
    end

    // reset, idle control and end of run
    initial begin
        int quiet;
        i_rst_n = 1'b0;
        calm = 1'b0;
        stim_done = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_sent > 300);
        calm = 1'b1;
        wait (n_sent > 500);
        calm = 1'b0;
        wait (offset_q.size() == 0 && !in_ch.valid);
        stim_done = 1'b1;
        wait (basis_q.size() == 0);
        quiet = 0;
        while (quiet < LATENCY + 10) begin
            @(posedge i_clk);
            quiet++;
        end
        $display("covered %0d vectors: %0d on the z axis, %0d zero, under idling and stall",
                 n_sent, n_axis, n_zero);
        if (n_err == 0) $display("spherical_unit_basis regression: pass");
        else $display("spherical_unit_basis regression: fail");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.vec_x <= '0;
            in_ch.vec_y <= '0;
            in_ch.vec_z <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                basis_q.push_back(spherical_frame({in_ch.vec_x, in_ch.vec_y, in_ch.vec_z}));
                n_sent++;
            end
            if (offset_q.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
                t_offset v;
                v = offset_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.vec_x <= v.x;
                in_ch.vec_y <= v.y;
                in_ch.vec_z <= v.z;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor with long output hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_basis want;
                if (basis_q.size() == 0) begin
                    n_err++;
                    $display("output transfer with nothing expected");
                end else begin
                    want = basis_q.pop_front();
                    if (out_ch.radial_x !== want.rx) report_mismatch("radial_x", out_ch.radial_x, want.rx);
                    if (out_ch.radial_y !== want.ry) report_mismatch("radial_y", out_ch.radial_y, want.ry);
                    if (out_ch.radial_z !== want.rz) report_mismatch("radial_z", out_ch.radial_z, want.rz);
                    if (out_ch.azim_x !== want.ax) report_mismatch("azim_x", out_ch.azim_x, want.ax);
                    if (out_ch.azim_y !== want.ay) report_mismatch("azim_y", out_ch.azim_y, want.ay);
                    if (out_ch.azim_z !== want.az) report_mismatch("azim_z", out_ch.azim_z, want.az);
                    if (out_ch.elev_x !== want.ex) report_mismatch("elev_x", out_ch.elev_x, want.ex);
                    if (out_ch.elev_y !== want.ey) report_mismatch("elev_y", out_ch.elev_y, want.ey);
                    if (out_ch.elev_z !== want.ez) report_mismatch("elev_z", out_ch.elev_z, want.ez);
                    if (out_ch.on_axis !== want.axis)
                        report_mismatch("on_axis", OUT_W'(out_ch.on_axis), OUT_W'(want.axis));
                    if (out_ch.zero_vector !== want.zero)
                        report_mismatch("zero_vector", OUT_W'(out_ch.zero_vector),
                                        OUT_W'(want.zero));
                    n_axis += int'(want.axis);
                    n_zero += int'(want.zero);
                end
                n_seen++;
            end
            // hold off for a long stretch once, mid-run
            if (n_sent > 600 && n_sent < 1000 && hold_cycles < 200) begin
                hold_cycles <= hold_cycles + 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || $urandom_range(0, 99) >= 9;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_MAX) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("spherical_unit_basis regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        n_err = 0;
        n_sent = 0;
        n_seen = 0;
        n_axis = 0;
        n_zero = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        in_ch.valid = 1'b0;
        in_ch.vec_x = '0;
        in_ch.vec_y = '0;
        in_ch.vec_z = '0;
        out_ch.ready = 1'b0;
    end
endmodule
